FILE: design/gclp_pkg.sv
// Shared types, constants and helpers for the G-code line parser.
// No dependencies; used by gcode_line_parser and gclp_checker.
`timescale 1ns / 1ps
`default_nettype none

package gclp_pkg;

    // Line buffer size; only the first LINE_BUFFER-1 characters count.
    localparam int LINE_BUFFER = 128;
    localparam int CNT_W       = $clog2(LINE_BUFFER);

    // Fraction digits kept; values are in units of 10^-FRAC_DIGITS.
    localparam int FRAC_DIGITS = 3;
    localparam int FD_W        = (FRAC_DIGITS < 1) ? 1 : $clog2(FRAC_DIGITS + 1);

    // Scaled magnitude accumulator, capped at 2^32.
    localparam int ACC_W = 33;
    localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, 32'b0};

    // Integer part of a G or M word, saturated; every supported code fits below the cap.
    localparam int INT_W = 7;
    localparam logic [INT_W-1:0] INT_CAP = '1;

    localparam int NUM_AXES = 6;  // X Y Z I J F

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    localparam logic [2:0] LTR_G = 3'd0;
    localparam logic [2:0] LTR_M = 3'd1;
    localparam logic [2:0] LTR_X = 3'd2;
    localparam logic [2:0] LTR_Y = 3'd3;
    localparam logic [2:0] LTR_Z = 3'd4;
    localparam logic [2:0] LTR_I = 3'd5;
    localparam logic [2:0] LTR_J = 3'd6;
    localparam logic [2:0] LTR_F = 3'd7;

    localparam logic [INT_W-1:0] G_RAPID    = 7'd0;
    localparam logic [INT_W-1:0] G_LINEAR   = 7'd1;
    localparam logic [INT_W-1:0] G_ARC_CW   = 7'd2;
    localparam logic [INT_W-1:0] G_ARC_CCW  = 7'd3;
    localparam logic [INT_W-1:0] G_UNITS_MM = 7'd21;
    localparam logic [INT_W-1:0] G_ABS      = 7'd90;
    localparam logic [INT_W-1:0] G_REL      = 7'd91;
    localparam logic [INT_W-1:0] G_SET_POS  = 7'd92;
    localparam logic [INT_W-1:0] M_SPINDLE_ON  = 7'd3;
    localparam logic [INT_W-1:0] M_SPINDLE_OFF = 7'd5;

    typedef enum logic [3:0] {
        KIND_EMPTY   = 4'd0,
        KIND_G0      = 4'd1,
        KIND_G1      = 4'd2,
        KIND_G2      = 4'd3,
        KIND_G3      = 4'd4,
        KIND_G21     = 4'd5,
        KIND_G90     = 4'd6,
        KIND_G91     = 4'd7,
        KIND_G92     = 4'd8,
        KIND_M3      = 4'd9,
        KIND_M5      = 4'd10,
        KIND_UNKNOWN = 4'd11
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NO_CODE     = 2'd1,
        STATUS_UNSUPPORTED = 2'd2
    } t_status;

    // Comment tracking: before the first block, inside it, after it.
    typedef enum logic [2:0] {
        CMT_NONE = 3'b001,
        CMT_IN   = 3'b010,
        CMT_DONE = 3'b100
    } t_cmt;

    typedef struct packed {
        logic       vld;
        logic [2:0] idx;
    } t_ltr;

    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int k = 0; k < n; k++) begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam longint SCALE = pow10(FRAC_DIGITS);

    // Weight of the next fraction digit, given how many are already in.
    function automatic logic [ACC_W-1:0] digit_weight(input logic [FD_W-1:0] fd);
        logic [ACC_W-1:0] w;
        w = '0;
        for (int k = 0; k < FRAC_DIGITS; k++) begin
            if (fd == FD_W'(k)) begin
                w = ACC_W'(pow10(FRAC_DIGITS - 1 - k));
            end
        end
        return w;
    endfunction

    function automatic t_ltr letter_code(input logic [7:0] c);
        t_ltr l;
        l.vld = 1'b1;
        unique case (c)
            8'h47:   l.idx = LTR_G;
            8'h4D:   l.idx = LTR_M;
            8'h58:   l.idx = LTR_X;
            8'h59:   l.idx = LTR_Y;
            8'h5A:   l.idx = LTR_Z;
            8'h49:   l.idx = LTR_I;
            8'h4A:   l.idx = LTR_J;
            8'h46:   l.idx = LTR_F;
            default: begin
                l.vld = 1'b0;
                l.idx = LTR_G;
            end
        endcase
        return l;
    endfunction

    // Signed 32-bit result from magnitude and sign, saturated.
    function automatic logic [31:0] sat_value(input logic [ACC_W-1:0] mag, input logic neg);
        logic [31:0] v;
        if (!neg) begin
            v = (mag > ACC_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
        end else begin
            v = (mag >= ACC_W'(32'h8000_0000)) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
        end
        return v;
    endfunction

    // A negative code with nonzero integer part never matches.
    function automatic t_kind g_kind(input logic [INT_W-1:0] m, input logic neg);
        t_kind k;
        if (neg && (m != G_RAPID)) begin
            k = KIND_UNKNOWN;
        end else begin
            unique case (m)
                G_RAPID:    k = KIND_G0;
                G_LINEAR:   k = KIND_G1;
                G_ARC_CW:   k = KIND_G2;
                G_ARC_CCW:  k = KIND_G3;
                G_UNITS_MM: k = KIND_G21;
                G_ABS:      k = KIND_G90;
                G_REL:      k = KIND_G91;
                G_SET_POS:  k = KIND_G92;
                default:    k = KIND_UNKNOWN;
            endcase
        end
        return k;
    endfunction

    function automatic t_kind m_kind(input logic [INT_W-1:0] m, input logic neg);
        t_kind k;
        if (neg && (m != '0)) begin
            k = KIND_UNKNOWN;
        end else begin
            unique case (m)
                M_SPINDLE_ON:  k = KIND_M3;
                M_SPINDLE_OFF: k = KIND_M5;
                default:       k = KIND_UNKNOWN;
            endcase
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: design/gcode_line_parser.sv
// G-code line parser: one character per beat, one result beat per line.
// Depends on gclp_pkg.
// Latency: the result beat is valid in the cycle after the line_end beat is accepted.
// Throughput: one input beat per cycle; input stalls only while a result is held
// by a stalled output. Per-line state is updated by one pass of logic per beat.
// Reset (synchronous, active low) clears the line state and drops any held result.
`timescale 1ns / 1ps
`default_nettype none

module gcode_line_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_has_char,
    input  wire logic        i_line_end,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_kind,
    output logic [1:0]       o_status,
    output logic [5:0]       o_present_mask,
    output logic [31:0]      o_x_value,
    output logic [31:0]      o_y_value,
    output logic [31:0]      o_z_value,
    output logic [31:0]      o_i_value,
    output logic [31:0]      o_j_value,
    output logic [31:0]      o_feed_value
);

    localparam int AW = gclp_pkg::ACC_W;
    localparam int IW = gclp_pkg::INT_W;
    localparam int NA = gclp_pkg::NUM_AXES;

    // line state
    gclp_pkg::t_cmt                r_cmt, n_cmt;
    logic                          r_trunc, n_trunc;
    logic [gclp_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    gclp_pkg::t_ltr                r_prev, n_prev;
    logic                          r_seen, n_seen;
    logic                          r_pct, n_pct;
    logic [7:0]                    r_found, n_found;
    logic                          r_act_vld, n_act_vld;
    logic [2:0]                    r_act_idx, n_act_idx;
    logic                          r_sign, n_sign;
    logic                          r_frac, n_frac;
    logic [gclp_pkg::FD_W-1:0]     r_fd, n_fd;
    logic [AW-1:0]                 r_acc, n_acc;
    logic [IW-1:0]                 r_int, n_int;
    logic [IW-1:0]                 r_g_int, n_g_int;
    logic                          r_g_neg, n_g_neg;
    logic [IW-1:0]                 r_m_int, n_m_int;
    logic                          r_m_neg, n_m_neg;
    logic [31:0]                   r_val [NA];
    logic [31:0]                   n_val [NA];

    // result register
    logic                          r_out_vld, n_out_vld;
    gclp_pkg::t_kind               r_kind, n_kind;
    gclp_pkg::t_status             r_status, n_status;
    logic [5:0]                    r_mask, n_mask;
    logic [31:0]                   r_oval [NA];
    logic [31:0]                   n_oval [NA];

    logic                          accept;
    logic                          take;
    logic [7:0]                    c_fold;
    logic                          c_digit;
    logic [3:0]                    c_d;
    logic                          c_blank;
    logic                          nonempty;
    logic [AW-1:0]                 d_scaled;
    logic [AW+3:0]                 acc_int_sum;
    logic [AW:0]                   acc_frac_sum;
    logic [IW+3:0]                 int_sum;
    logic [31:0]                   fin_v;

    assign o_in_stall = r_out_vld & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign take       = accept & i_has_char & ~r_trunc
                      & (r_cnt < gclp_pkg::CNT_W'(gclp_pkg::LINE_BUFFER - 1));

    assign c_fold  = ((i_ch >= gclp_pkg::CH_LOW_A) && (i_ch <= gclp_pkg::CH_LOW_Z))
                   ? (i_ch - gclp_pkg::CASE_SHIFT) : i_ch;
    assign c_digit = (c_fold >= gclp_pkg::CH_ZERO) && (c_fold <= gclp_pkg::CH_NINE);
    assign c_d     = 4'(c_fold - gclp_pkg::CH_ZERO);
    assign c_blank = (c_fold == gclp_pkg::CH_SPACE) || (c_fold == gclp_pkg::CH_TAB);

    // Magnitude kept pre-scaled to the output unit, so a new integer digit is
    // acc*10 + d*SCALE and a fraction digit adds d at its own weight.
    assign d_scaled     = AW'(gclp_pkg::SCALE) * AW'(c_d);
    assign acc_int_sum  = (AW+4)'({r_acc, 3'b000}) + (AW+4)'({r_acc, 1'b0}) + (AW+4)'(d_scaled);
    assign acc_frac_sum = (AW+1)'(r_acc) + (AW+1)'(gclp_pkg::digit_weight(r_fd) * AW'(c_d));
    assign int_sum      = (IW+4)'({r_int, 3'b000}) + (IW+4)'({r_int, 1'b0}) + (IW+4)'(c_d);

    always_comb begin
        n_cmt     = r_cmt;
        n_trunc   = r_trunc;
        n_cnt     = r_cnt;
        n_prev    = r_prev;
        n_seen    = r_seen;
        n_pct     = r_pct;
        n_found   = r_found;
        n_act_vld = r_act_vld;
        n_act_idx = r_act_idx;
        n_sign    = r_sign;
        n_frac    = r_frac;
        n_fd      = r_fd;
        n_acc     = r_acc;
        n_int     = r_int;
        n_g_int   = r_g_int;
        n_g_neg   = r_g_neg;
        n_m_int   = r_m_int;
        n_m_neg   = r_m_neg;
        n_val     = r_val;
        fin_v     = '0;

        if (take) begin
            n_cnt = r_cnt + 1'b1;
            if (i_ch == gclp_pkg::CH_NUL) begin
                n_trunc = 1'b1;
            end else if (r_cmt == gclp_pkg::CMT_IN) begin
                if (i_ch == gclp_pkg::CH_RPAREN) begin
                    n_cmt = gclp_pkg::CMT_DONE;
                end
            end else if ((r_cmt == gclp_pkg::CMT_NONE) && (i_ch == gclp_pkg::CH_LPAREN)) begin
                n_cmt = gclp_pkg::CMT_IN;
            end else if (i_ch == gclp_pkg::CH_SEMI) begin
                n_trunc = 1'b1;
            end else if (!r_seen && c_blank) begin
                n_prev = '0;
            end else begin
                n_seen = 1'b1;
                n_pct  = !r_seen && (c_fold == gclp_pkg::CH_PERCENT);

                if (r_act_vld) begin
                    if (c_digit) begin
                        if (!r_frac) begin
                            n_acc = (acc_int_sum > (AW+4)'(gclp_pkg::ACC_CAP))
                                  ? gclp_pkg::ACC_CAP : acc_int_sum[AW-1:0];
                            n_int = (int_sum > (IW+4)'(gclp_pkg::INT_CAP))
                                  ? gclp_pkg::INT_CAP : int_sum[IW-1:0];
                        end else if (r_fd < gclp_pkg::FD_W'(gclp_pkg::FRAC_DIGITS)) begin
                            n_acc = (acc_frac_sum > (AW+1)'(gclp_pkg::ACC_CAP))
                                  ? gclp_pkg::ACC_CAP : acc_frac_sum[AW-1:0];
                            n_fd  = r_fd + 1'b1;
                        end
                    end else if ((c_fold == gclp_pkg::CH_DOT) && !r_frac) begin
                        n_frac = 1'b1;
                    end else begin
                        // number ends here
                        fin_v     = gclp_pkg::sat_value(r_acc, r_sign);
                        n_act_vld = 1'b0;
                        if (r_act_idx == gclp_pkg::LTR_G) begin
                            n_g_int = r_int;
                            n_g_neg = r_sign;
                        end else if (r_act_idx == gclp_pkg::LTR_M) begin
                            n_m_int = r_int;
                            n_m_neg = r_sign;
                        end
                        for (int k = 0; k < NA; k++) begin
                            if (r_act_idx == 3'(k + 2)) begin
                                n_val[k] = fin_v;
                            end
                        end
                    end
                end

                // first use of a letter followed by a number start
                if (r_prev.vld && !r_found[r_prev.idx] &&
                    (c_digit || (c_fold == gclp_pkg::CH_MINUS) ||
                     (c_fold == gclp_pkg::CH_DOT))) begin
                    n_found[r_prev.idx] = 1'b1;
                    n_act_vld = 1'b1;
                    n_act_idx = r_prev.idx;
                    n_sign    = (c_fold == gclp_pkg::CH_MINUS);
                    n_frac    = (c_fold == gclp_pkg::CH_DOT);
                    n_fd      = '0;
                    n_acc     = c_digit ? d_scaled : '0;
                    n_int     = c_digit ? IW'(c_d) : '0;
                end

                n_prev = gclp_pkg::letter_code(c_fold);
            end
        end

        // line end: close any open number, then build the result
        if (accept && i_line_end && n_act_vld) begin
            fin_v = gclp_pkg::sat_value(n_acc, n_sign);
            if (n_act_idx == gclp_pkg::LTR_G) begin
                n_g_int = n_int;
                n_g_neg = n_sign;
            end else if (n_act_idx == gclp_pkg::LTR_M) begin
                n_m_int = n_int;
                n_m_neg = n_sign;
            end
            for (int k = 0; k < NA; k++) begin
                if (n_act_idx == 3'(k + 2)) begin
                    n_val[k] = fin_v;
                end
            end
        end

        nonempty = n_seen && !n_pct;
        if (!nonempty) begin
            n_kind   = gclp_pkg::KIND_EMPTY;
            n_status = gclp_pkg::STATUS_OK;
        end else if (n_found[gclp_pkg::LTR_G]) begin
            n_kind   = gclp_pkg::g_kind(n_g_int, n_g_neg);
            n_status = (n_kind == gclp_pkg::KIND_UNKNOWN)
                     ? gclp_pkg::STATUS_UNSUPPORTED : gclp_pkg::STATUS_OK;
        end else if (n_found[gclp_pkg::LTR_M]) begin
            n_kind   = gclp_pkg::m_kind(n_m_int, n_m_neg);
            n_status = (n_kind == gclp_pkg::KIND_UNKNOWN)
                     ? gclp_pkg::STATUS_UNSUPPORTED : gclp_pkg::STATUS_OK;
        end else begin
            n_kind   = gclp_pkg::KIND_UNKNOWN;
            n_status = gclp_pkg::STATUS_NO_CODE;
        end
        n_mask = (nonempty && (n_status == gclp_pkg::STATUS_OK)) ? n_found[7:2] : '0;
        for (int k = 0; k < NA; k++) begin
            n_oval[k] = n_mask[k] ? n_val[k] : '0;
        end

        if (accept && i_line_end) begin
            n_out_vld = 1'b1;
            n_cmt     = gclp_pkg::CMT_NONE;
            n_trunc   = 1'b0;
            n_cnt     = '0;
            n_prev    = '0;
            n_seen    = 1'b0;
            n_pct     = 1'b0;
            n_found   = '0;
            n_act_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld & i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmt     <= gclp_pkg::CMT_NONE;
            r_trunc   <= 1'b0;
            r_cnt     <= '0;
            r_prev    <= '0;
            r_seen    <= 1'b0;
            r_pct     <= 1'b0;
            r_found   <= '0;
            r_act_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmt     <= n_cmt;
            r_trunc   <= n_trunc;
            r_cnt     <= n_cnt;
            r_prev    <= n_prev;
            r_seen    <= n_seen;
            r_pct     <= n_pct;
            r_found   <= n_found;
            r_act_vld <= n_act_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act_idx <= n_act_idx;
        r_sign    <= n_sign;
        r_frac    <= n_frac;
        r_fd      <= n_fd;
        r_acc     <= n_acc;
        r_int     <= n_int;
        r_g_int   <= n_g_int;
        r_g_neg   <= n_g_neg;
        r_m_int   <= n_m_int;
        r_m_neg   <= n_m_neg;
        r_val     <= n_val;
        if (accept && i_line_end) begin
            r_kind   <= n_kind;
            r_status <= n_status;
            r_mask   <= n_mask;
            r_oval   <= n_oval;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_kind         = r_kind;
    assign o_status       = r_status;
    assign o_present_mask = r_mask;
    assign o_x_value      = r_oval[0];
    assign o_y_value      = r_oval[1];
    assign o_z_value      = r_oval[2];
    assign o_i_value      = r_oval[3];
    assign o_j_value      = r_oval[4];
    assign o_feed_value   = r_oval[5];

endmodule

`default_nettype wire

FILE: design/gclp_checker.sv
// Port-level checks for gcode_line_parser, attached by bind.
// Depends on gclp_pkg and gcode_line_parser.
`timescale 1ns / 1ps
`default_nettype none

module gclp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [7:0]  i_ch,
    input wire logic        i_has_char,
    input wire logic        i_line_end,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [3:0]  o_kind,
    input wire logic [1:0]  o_status,
    input wire logic [5:0]  o_present_mask,
    input wire logic [31:0] o_x_value,
    input wire logic [31:0] o_y_value,
    input wire logic [31:0] o_z_value,
    input wire logic [31:0] o_i_value,
    input wire logic [31:0] o_j_value,
    input wire logic [31:0] o_feed_value
);

    // held result beat stays up while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // every accepted line end yields a result beat next cycle
    a_line_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_line_end) |=> o_out_valid)
        else $error("line end gave no result");

    // input is held back only by a full, stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // errors and empty lines carry no words
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_status != gclp_pkg::STATUS_OK) ||
                         (o_kind == gclp_pkg::KIND_EMPTY)))
        |-> (o_present_mask == 6'd0 && o_x_value == 32'd0 && o_feed_value == 32'd0))
        else $error("word values on error or empty line");

    // nonzero status only with the unknown kind
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != gclp_pkg::STATUS_OK))
        |-> (o_kind == gclp_pkg::KIND_UNKNOWN))
        else $error("error status with a known kind");

endmodule

bind gcode_line_parser gclp_checker u_gclp_checker (.*);

`default_nettype wire
